// ===== rtl/rpn_stack_integer_alu_assert.svh =====
// assertion macros used by the checker file
`ifndef RPN_STACK_INTEGER_ALU_ASSERT_SVH
`define RPN_STACK_INTEGER_ALU_ASSERT_SVH

// same-cycle implication, sampled on the rising clock, off during reset
`define RPNALU_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rpn alu assertion failed");

// next-cycle implication, sampled on the rising clock, off during reset
`define RPNALU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rpn alu assertion failed");

`endif

// ===== rtl/rpnalu_pkg.sv =====
`default_nettype none

package rpnalu_pkg;

  localparam int DEF_STACK_DEPTH = 128;
  localparam int DEF_VALUE_BITS  = 32;

  // fixed widths of the word fields
  localparam int ACTION_BITS = 3;
  localparam int FIELD_BITS  = 32;

  typedef enum logic [ACTION_BITS-1:0] {
    ACT_PUSH  = 3'd0,
    ACT_ADD   = 3'd1,
    ACT_SUB   = 3'd2,
    ACT_MUL   = 3'd3,
    ACT_DIV   = 3'd4,
    ACT_MOD   = 3'd5,
    ACT_PRINT = 3'd6
  } action_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_ZDIV  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    MD_MUL = 2'd0,
    MD_DIV = 2'd1,
    MD_REM = 2'd2
  } md_op_e;

  typedef struct packed {
    logic   start;
    md_op_e op;
  } md_req_t;

endpackage

`default_nettype wire

// ===== rtl/rpn_stack_integer_alu.sv =====
`default_nettype none

// channel   direction  handshake               payload
// in        sink       in_valid_i / in_ready_o  action_i, operand_i
// out       source     out_valid_o / out_ready_i status_o, result_o, printed_o
//
// one word in, one word out; a word is taken only in the idle state
// push and unused action go straight to finish, print and zero divisor after the
// right pop, add and subtract after both pops, multiply, divide and modulo after the
// shared unit, one bit a cycle; one registered stack read port pops right then left
// reset empties the stack by clearing the pointer; entries are not cleared
// an untaken result holds the output register; one more word enters and waits

module rpn_stack_integer_alu #(
  parameter int STACK_DEPTH = rpnalu_pkg::DEF_STACK_DEPTH,
  parameter int VALUE_BITS  = rpnalu_pkg::DEF_VALUE_BITS
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  in_valid_i,
  output logic                                 in_ready_o,
  input  wire  [rpnalu_pkg::ACTION_BITS-1:0]   action_i,
  input  wire  signed [rpnalu_pkg::FIELD_BITS-1:0] operand_i,
  output logic                                 out_valid_o,
  input  wire                                  out_ready_i,
  output logic [1:0]                           status_o,
  output logic signed [rpnalu_pkg::FIELD_BITS-1:0] result_o,
  output logic                                 printed_o
);

  localparam int W   = VALUE_BITS;
  localparam int FB  = rpnalu_pkg::FIELD_BITS;
  localparam int AW  = $clog2(STACK_DEPTH);
  localparam int SPW = $clog2(STACK_DEPTH + 1);

  // one-hot sequencer
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_POPR = 5'b00010,
    S_POPL = 5'b00100,
    S_CALC = 5'b01000,
    S_FIN  = 5'b10000
  } state_e;

  state_e               state_q, state_d;
  logic [SPW-1:0]       sp_q, sp_d;
  logic [SPW-1:0]       sp_dec;
  logic                 sp_empty, sp_full;
  rpnalu_pkg::action_e  act_q, act_d;
  rpnalu_pkg::action_e  act_in;
  rpnalu_pkg::status_e  st_q, st_d;
  logic                 under_q, under_d;   // any pop hit an empty stack
  logic                 lmiss_q, lmiss_d;   // left operand pop hit an empty stack
  logic [W-1:0]         r_q, r_d;
  logic [W-1:0]         res_q, res_d;
  logic                 prt_q, prt_d;

  // output register
  logic                 out_valid_q, out_valid_d;
  rpnalu_pkg::status_e  out_status_q, out_status_d;
  logic [FB-1:0]        out_result_q, out_result_d;
  logic                 out_printed_q, out_printed_d;

  // stack memory
  logic [W-1:0]         mem [STACK_DEPTH];
  logic                 mem_we, mem_re;
  logic [AW-1:0]        mem_waddr, mem_raddr;
  logic [W-1:0]         mem_wdata;
  logic [W-1:0]         mem_rdata_q;

  // arithmetic unit
  rpnalu_pkg::md_req_t  md_req;
  logic                 md_done;
  logic [W-1:0]         md_res;

  logic [W-1:0]         rval, lval;

  assign sp_empty = (sp_q == '0);
  assign sp_full  = (sp_q == SPW'(STACK_DEPTH));
  assign sp_dec   = sp_q - SPW'(1);
  assign act_in   = rpnalu_pkg::action_e'(action_i);

  // popped values read as zero when the pop found the stack empty
  assign rval = under_q ? '0 : mem_rdata_q;
  assign lval = lmiss_q ? '0 : mem_rdata_q;

  always_comb begin
    state_d   = state_q;
    sp_d      = sp_q;
    act_d     = act_q;
    st_d      = st_q;
    under_d   = under_q;
    lmiss_d   = lmiss_q;
    r_d       = r_q;
    res_d     = res_q;
    prt_d     = prt_q;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = sp_q[AW-1:0];
    mem_raddr = sp_dec[AW-1:0];
    mem_wdata = '0;
    md_req    = '{start: 1'b0, op: rpnalu_pkg::MD_MUL};
    in_ready_o = 1'b0;

    out_valid_d   = out_valid_q && !out_ready_i;
    out_status_d  = out_status_q;
    out_result_d  = out_result_q;
    out_printed_d = out_printed_q;

    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          act_d   = act_in;
          st_d    = rpnalu_pkg::ST_OK;
          under_d = 1'b0;
          lmiss_d = 1'b0;
          res_d   = '0;
          prt_d   = 1'b0;
          unique case (act_in)
            rpnalu_pkg::ACT_PUSH: begin
              if (!sp_full) begin
                mem_we    = 1'b1;
                mem_wdata = W'(operand_i);
                sp_d      = sp_q + SPW'(1);
              end else begin
                st_d = rpnalu_pkg::ST_FULL;
              end
              state_d = S_FIN;
            end
            rpnalu_pkg::ACT_ADD, rpnalu_pkg::ACT_SUB, rpnalu_pkg::ACT_MUL,
            rpnalu_pkg::ACT_DIV, rpnalu_pkg::ACT_MOD, rpnalu_pkg::ACT_PRINT: begin
              // pop the right operand (or the value to print)
              if (!sp_empty) begin
                mem_re = 1'b1;
                sp_d   = sp_dec;
              end else begin
                under_d = 1'b1;
              end
              state_d = S_POPR;
            end
            default: begin
              // unused code: no stack change, plain ok word
              state_d = S_FIN;
            end
          endcase
        end
      end

      S_POPR: begin
        r_d = rval;
        if (act_q == rpnalu_pkg::ACT_PRINT) begin
          res_d   = rval;
          prt_d   = 1'b1;
          st_d    = under_q ? rpnalu_pkg::ST_EMPTY : rpnalu_pkg::ST_OK;
          state_d = S_FIN;
        end else if ((act_q == rpnalu_pkg::ACT_DIV || act_q == rpnalu_pkg::ACT_MOD)
                     && (rval == '0)) begin
          // zero divisor: left operand stays, nothing pushed
          st_d    = under_q ? rpnalu_pkg::ST_EMPTY : rpnalu_pkg::ST_ZDIV;
          state_d = S_FIN;
        end else begin
          if (!sp_empty) begin
            mem_re = 1'b1;
            sp_d   = sp_dec;
          end else begin
            under_d = 1'b1;
            lmiss_d = 1'b1;
          end
          state_d = S_POPL;
        end
      end

      S_POPL: begin
        // two pops leave room, so the push below always fits
        st_d = under_q ? rpnalu_pkg::ST_EMPTY : rpnalu_pkg::ST_OK;
        unique case (act_q)
          rpnalu_pkg::ACT_ADD: begin
            mem_we    = 1'b1;
            mem_wdata = lval + r_q;
            res_d     = lval + r_q;
            sp_d      = sp_q + SPW'(1);
            state_d   = S_FIN;
          end
          rpnalu_pkg::ACT_SUB: begin
            mem_we    = 1'b1;
            mem_wdata = lval - r_q;
            res_d     = lval - r_q;
            sp_d      = sp_q + SPW'(1);
            state_d   = S_FIN;
          end
          rpnalu_pkg::ACT_MUL: begin
            md_req  = '{start: 1'b1, op: rpnalu_pkg::MD_MUL};
            state_d = S_CALC;
          end
          rpnalu_pkg::ACT_DIV: begin
            md_req  = '{start: 1'b1, op: rpnalu_pkg::MD_DIV};
            state_d = S_CALC;
          end
          default: begin
            md_req  = '{start: 1'b1, op: rpnalu_pkg::MD_REM};
            state_d = S_CALC;
          end
        endcase
      end

      S_CALC: begin
        if (md_done) begin
          mem_we    = 1'b1;
          mem_wdata = md_res;
          res_d     = md_res;
          sp_d      = sp_q + SPW'(1);
          state_d   = S_FIN;
        end
      end

      S_FIN: begin
        // hand over once the output register is free
        if (!out_valid_q || out_ready_i) begin
          out_valid_d   = 1'b1;
          out_status_d  = st_q;
          out_result_d  = FB'(signed'(res_q));
          out_printed_d = prt_q;
          state_d       = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  rpnalu_muldiv #(
    .VALUE_BITS(VALUE_BITS)
  ) u_muldiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (md_req),
    .a_i    (lval),
    .b_i    (r_q),
    .done_o (md_done),
    .res_o  (md_res)
  );

  // synchronous stack memory, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_q <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      sp_q        <= '0;
      out_valid_q <= 1'b0;
      act_q       <= rpnalu_pkg::ACT_PUSH;
      st_q        <= rpnalu_pkg::ST_OK;
      under_q     <= 1'b0;
      lmiss_q     <= 1'b0;
      prt_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      sp_q        <= sp_d;
      out_valid_q <= out_valid_d;
      act_q       <= act_d;
      st_q        <= st_d;
      under_q     <= under_d;
      lmiss_q     <= lmiss_d;
      prt_q       <= prt_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    r_q           <= r_d;
    res_q         <= res_d;
    out_status_q  <= out_status_d;
    out_result_q  <= out_result_d;
    out_printed_q <= out_printed_d;
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign result_o    = out_result_q;
  assign printed_o   = out_printed_q;

endmodule

`default_nettype wire

// ===== rtl/rpnalu_muldiv.sv =====
`default_nettype none

// shared iterative unit: shift-add multiply or restoring divide, one bit a cycle
module rpnalu_muldiv #(
  parameter int VALUE_BITS = rpnalu_pkg::DEF_VALUE_BITS
) (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  rpnalu_pkg::md_req_t       req_i,
  input  wire  [VALUE_BITS-1:0]     a_i,
  input  wire  [VALUE_BITS-1:0]     b_i,
  output logic                      done_o,
  output logic [VALUE_BITS-1:0]     res_o
);

  localparam int W  = VALUE_BITS;
  localparam int CW = $clog2(W + 1);

  logic                busy_q, busy_d;
  logic [CW-1:0]       cnt_q, cnt_d;
  rpnalu_pkg::md_op_e  op_q, op_d;
  logic                nl_q, nl_d, nr_q, nr_d;
  logic [W-1:0]        acc_q, acc_d;
  logic [W-1:0]        sh_q, sh_d;
  logic [W-1:0]        m_q, m_d;
  logic [W:0]          rem_sh;
  logic [W+1:0]        diff;
  logic [W-1:0]        mag_a, mag_b;

  assign mag_a  = a_i[W-1] ? (W'(0) - a_i) : a_i;
  assign mag_b  = b_i[W-1] ? (W'(0) - b_i) : b_i;
  assign rem_sh = {acc_q, sh_q[W-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, m_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    op_d   = op_q;
    nl_d   = nl_q;
    nr_d   = nr_q;
    acc_d  = acc_q;
    sh_d   = sh_q;
    m_d    = m_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = CW'(W);
      op_d   = req_i.op;
      nl_d   = a_i[W-1];
      nr_d   = b_i[W-1];
      acc_d  = '0;
      if (req_i.op == rpnalu_pkg::MD_MUL) begin
        sh_d = b_i;
        m_d  = a_i;
      end else begin
        sh_d = mag_a;
        m_d  = mag_b;
      end
    end else if (busy_q) begin
      if (cnt_q != '0) begin
        cnt_d = cnt_q - CW'(1);
        if (op_q == rpnalu_pkg::MD_MUL) begin
          if (sh_q[0]) begin
            acc_d = acc_q + m_q;
          end
          m_d  = {m_q[W-2:0], 1'b0};
          sh_d = {1'b0, sh_q[W-1:1]};
        end else begin
          // restoring step: keep the difference when it does not borrow
          if (!diff[W+1]) begin
            acc_d = diff[W-1:0];
          end else begin
            acc_d = rem_sh[W-1:0];
          end
          sh_d = {sh_q[W-2:0], ~diff[W+1]};
        end
      end else begin
        busy_d = 1'b0;
      end
    end
  end

  assign done_o = busy_q && (cnt_q == '0);

  always_comb begin
    unique case (op_q)
      rpnalu_pkg::MD_MUL: res_o = acc_q;
      rpnalu_pkg::MD_DIV: res_o = (nl_q ^ nr_q) ? (W'(0) - sh_q) : sh_q;
      rpnalu_pkg::MD_REM: res_o = nl_q ? (W'(0) - acc_q) : acc_q;
      default:            res_o = acc_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      op_q   <= rpnalu_pkg::MD_MUL;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      op_q   <= op_d;
    end
  end

  always_ff @(posedge clk_i) begin
    nl_q  <= nl_d;
    nr_q  <= nr_d;
    acc_q <= acc_d;
    sh_q  <= sh_d;
    m_q   <= m_d;
  end

endmodule

`default_nettype wire

// ===== rtl/rpnalu_checker.sv =====
`default_nettype none

`include "rpn_stack_integer_alu_assert.svh"

module rpnalu_checker (
  input wire                                   clk_i,
  input wire                                   rst_ni,
  input wire                                   in_valid_i,
  input wire                                   in_ready_o,
  input wire                                   out_valid_o,
  input wire                                   out_ready_i,
  input wire [1:0]                             status_o,
  input wire [rpnalu_pkg::FIELD_BITS-1:0]      result_o,
  input wire                                   printed_o
);

  logic out_stall;
  logic fail_word;
  logic empty_print;

  assign out_stall   = out_valid_o && !out_ready_i;
  assign fail_word   = out_valid_o && (status_o == rpnalu_pkg::ST_FULL ||
                                       status_o == rpnalu_pkg::ST_ZDIV);
  assign empty_print = out_valid_o && printed_o && (status_o == rpnalu_pkg::ST_EMPTY);

  // a stalled word holds
  `RPNALU_ASSERT_NEXT(a_out_hold, out_stall, out_valid_o && $stable(result_o) && $stable(status_o))

  // one word at a time: after a word is taken the input closes
  `RPNALU_ASSERT_NEXT(a_one_at_a_time, in_valid_i && in_ready_o, !in_ready_o)

  // full stack and zero divisor push nothing and show no value
  `RPNALU_ASSERT_NOW(a_fail_zero, fail_word, result_o == '0 && !printed_o)

  // printing from an empty stack shows zero
  `RPNALU_ASSERT_NOW(a_print_empty, empty_print, result_o == '0)

endmodule

bind rpn_stack_integer_alu rpnalu_checker u_rpnalu_checker (.*);

`default_nettype wire
